// ===== src/gnkr_pkg.sv =====
// Shared types, constants and key mapping for the gamepad navigation key repeater.
// Used by every module under src; depends on nothing.
package gnkr_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEADZONE = 2'd0;
  localparam logic [1:0] CFG_FIRST_DELAY = 2'd1;
  localparam logic [1:0] CFG_INTERVAL = 2'd2;

  // Configuration reset values
  localparam logic [14:0] DEADZONE_RST = 15'd16000;
  localparam logic [15:0] FIRST_DELAY_RST = 16'd380;
  localparam logic [15:0] INTERVAL_RST = 16'd110;

  // Held direction codes
  localparam logic [2:0] DIR_NONE = 3'd0;
  localparam logic [2:0] DIR_LEFT = 3'd1;
  localparam logic [2:0] DIR_RIGHT = 3'd2;
  localparam logic [2:0] DIR_UP = 3'd3;
  localparam logic [2:0] DIR_DOWN = 3'd4;

  // Key codes
  localparam logic [3:0] KEY_ENTER = 4'd4;
  localparam logic [3:0] KEY_ESCAPE = 4'd5;
  localparam logic [3:0] KEY_PAGEUP = 4'd6;
  localparam logic [3:0] KEY_PAGEDOWN = 4'd7;
  localparam logic [3:0] KEY_FULLSCREEN = 4'd8;

  // Button bit positions
  localparam int BTN_DLEFT = 0;
  localparam int BTN_DRIGHT = 1;
  localparam int BTN_DUP = 2;
  localparam int BTN_DDOWN = 3;
  localparam int BTN_A = 4;
  localparam int BTN_B = 5;
  localparam int BTN_LSHOULDER = 6;
  localparam int BTN_RSHOULDER = 7;
  localparam int BTN_START = 8;
  localparam int BTN_BACK = 9;

  // Fire slots in emission order: slot 0 is the direction key
  localparam int NUM_SLOTS = 7;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic        connected;
    logic        focused;
    logic [9:0]  buttons;
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [3:0] key_code;
    logic       last_key;
  } out_word_t;

  // One classified sample: which keys fire and the direction key code
  typedef struct packed {
    logic [1:0]           dir_code;
    logic [NUM_SLOTS-1:0] fire;
  } q_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Map a fire slot to its key code
  function automatic logic [3:0] slot_key(input logic [2:0] slot, input logic [1:0] dir_code);
    logic [3:0] k;
    unique case (slot)
      3'd0:    k = {2'b00, dir_code};
      3'd1:    k = KEY_ENTER;
      3'd2:    k = KEY_ESCAPE;
      3'd3:    k = KEY_PAGEUP;
      3'd4:    k = KEY_PAGEDOWN;
      3'd5:    k = KEY_FULLSCREEN;
      3'd6:    k = KEY_ESCAPE;
      default: k = KEY_ESCAPE;
    endcase
    return k;
  endfunction

endpackage

// ===== src/gnkr_front.sv =====
// Front end: holds configuration and repeat state, classifies each sample into a fire mask.
// Depends on gnkr_pkg.
module gnkr_front
  import gnkr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic       accept,
  input  in_word_t   in_word,
  output logic       q_push,
  output q_word_t    q_wdata
);

  logic [14:0] deadzone_r;
  logic [15:0] first_delay_r;
  logic [15:0] interval_r;
  logic [9:0]  prev_btn_r, prev_btn_nxt;
  logic        base_valid_r, base_valid_nxt;
  logic [2:0]  held_dir_r, held_dir_nxt;
  logic [31:0] next_fire_r, next_fire_nxt;

  logic signed [16:0] sx, sy, dz_pos, dz_neg;
  logic [2:0]  dir;
  logic [31:0] since;
  logic        due, dir_fire;
  logic [9:0]  pressed;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r    <= DEADZONE_RST;
      first_delay_r <= FIRST_DELAY_RST;
      interval_r    <= INTERVAL_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_DEADZONE:    deadzone_r    <= cfg_data[14:0];
        CFG_FIRST_DELAY: first_delay_r <= cfg_data;
        CFG_INTERVAL:    interval_r    <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Resolve direction with priority left, right, up, down
  always_comb begin
    sx     = {in_word.stick_x[15], in_word.stick_x};
    sy     = {in_word.stick_y[15], in_word.stick_y};
    dz_pos = signed'({2'b00, deadzone_r});
    dz_neg = -dz_pos;
    priority if (in_word.buttons[BTN_DLEFT] || (sx < dz_neg)) dir = DIR_LEFT;
    else if (in_word.buttons[BTN_DRIGHT] || (sx > dz_pos))    dir = DIR_RIGHT;
    else if (in_word.buttons[BTN_DUP] || (sy > dz_pos))       dir = DIR_UP;
    else if (in_word.buttons[BTN_DDOWN] || (sy < dz_neg))     dir = DIR_DOWN;
    else                                                     dir = DIR_NONE;
  end

  // Classify the sample and advance repeat state
  always_comb begin
    since          = in_word.now_ms - next_fire_r;
    due            = ~since[31];
    dir_fire       = 1'b0;
    prev_btn_nxt   = prev_btn_r;
    base_valid_nxt = base_valid_r;
    held_dir_nxt   = held_dir_r;
    next_fire_nxt  = next_fire_r;
    pressed        = '0;
    if (!in_word.connected) begin
      prev_btn_nxt   = '0;
      base_valid_nxt = 1'b0;
      held_dir_nxt   = DIR_NONE;
    end else if (!in_word.focused) begin
      prev_btn_nxt   = in_word.buttons;
      base_valid_nxt = 1'b0;
      held_dir_nxt   = DIR_NONE;
    end else begin
      if (dir == DIR_NONE) begin
        held_dir_nxt = DIR_NONE;
      end else if (dir != held_dir_r) begin
        dir_fire      = 1'b1;
        held_dir_nxt  = dir;
        next_fire_nxt = in_word.now_ms + {16'd0, first_delay_r};
      end else if (due) begin
        dir_fire      = 1'b1;
        next_fire_nxt = in_word.now_ms + {16'd0, interval_r};
      end
      if (base_valid_r) pressed = in_word.buttons & ~prev_btn_r;
      base_valid_nxt = 1'b1;
      prev_btn_nxt   = in_word.buttons;
    end
  end

  // Pack the fire mask in emission order
  always_comb begin
    q_wdata.dir_code = 2'(dir - 3'd1);
    q_wdata.fire     = {pressed[BTN_BACK], pressed[BTN_START], pressed[BTN_RSHOULDER],
                        pressed[BTN_LSHOULDER], pressed[BTN_B], pressed[BTN_A], dir_fire};
    q_push           = accept && (q_wdata.fire != '0);
  end

  // Hold repeat state between samples
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_btn_r   <= '0;
      base_valid_r <= 1'b0;
      held_dir_r   <= DIR_NONE;
      next_fire_r  <= '0;
    end else if (accept) begin
      prev_btn_r   <= prev_btn_nxt;
      base_valid_r <= base_valid_nxt;
      held_dir_r   <= held_dir_nxt;
      next_fire_r  <= next_fire_nxt;
    end
  end

  // Held direction only changes to the direction just resolved or to none
  a_held_dir: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (held_dir_r == DIR_NONE) || (held_dir_r == $past(dir)))
    else $error("held direction took an unresolved value");

  // Without a valid baseline no button key is queued
  a_no_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !base_valid_r) |-> (q_wdata.fire[NUM_SLOTS-1:1] == '0))
    else $error("button key queued without baseline");

  // A disconnected or unfocused sample queues nothing
  a_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !(in_word.connected && in_word.focused)) |-> !q_push)
    else $error("key queued for silent sample");

endmodule

// ===== src/gnkr_queue.sv =====
// Short queue of classified samples between front and back.
// Depends on gnkr_pkg.
module gnkr_queue
  import gnkr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_word_t wdata,
  input  logic    pop,
  output q_word_t rdata,
  output q_stat_t stat
);

  q_word_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;

  assign stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign rdata      = mem_r[rd_ptr_r];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

endmodule

// ===== src/gnkr_back.sv =====
// Back end: takes fire masks from the queue and emits one key word per cycle
// while the output is free and a mask is loaded. Depends on gnkr_pkg.
module gnkr_back
  import gnkr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  q_word_t   q_rdata,
  input  q_stat_t   q_stat,
  output logic      q_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output out_word_t out_word
);

  logic [NUM_SLOTS-1:0] work_r, work_nxt;
  logic [1:0]           dcode_r;
  logic                 out_valid_r;
  out_word_t            out_r;

  logic [NUM_SLOTS-1:0] pick;
  logic [2:0]           slot;
  logic                 out_free, emit;

  assign out_free  = !out_valid_r || out_pop;
  assign emit      = out_free && (work_r != '0);
  assign q_pop     = (work_r == '0) && !q_stat.empty;
  assign out_empty = !out_valid_r;
  assign out_word  = out_r;

  // Select the lowest pending slot
  always_comb begin
    pick = '0;
    slot = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (work_r[i]) begin
        pick = '0;
        pick[i] = 1'b1;
        slot = 3'(i);
      end
    end
  end

  // Load a new mask or drop the emitted slot
  always_comb begin
    work_nxt = work_r;
    if (q_pop)     work_nxt = q_rdata.fire;
    else if (emit) work_nxt = work_r & ~pick;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_r <= '0;
    end else begin
      work_r <= work_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) dcode_r <= q_rdata.dir_code;
  end

  // Fill the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r.key_code <= slot_key(slot, dcode_r);
      out_r.last_key <= ((work_r & ~pick) == '0);
    end
  end

  // Last marker goes out exactly when the mask runs dry
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (out_r.last_key == (work_r == '0)))
    else $error("last marker out of step with pending mask");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !emit)
    else $error("queue popped while mask pending");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.key_code <= KEY_FULLSCREEN))
    else $error("key code out of range");

endmodule

// ===== src/gamepad_nav_key_repeater_top.sv =====
// Top level of the gamepad navigation key repeater: front, queue and back end.
// Depends on gnkr_pkg, gnkr_front, gnkr_queue and gnkr_back.
//
// Usage:
//   Input channel: drive in_word and raise in_push; a sample is taken at an edge where
//   in_push is high and in_full is low. Each sample is classified in the cycle it is taken.
//   Result channel: while out_empty is low, out_word holds the oldest key word; raise
//   out_pop to take it. The final key of a sample carries last_key; a sample that fires
//   nothing produces no word at all.
//   Configuration: cfg_ready is always high; write cfg_index/cfg_data with cfg_valid only
//   while the block is idle. Index 0 deadzone, 1 first repeat delay, 2 repeat interval;
//   index 3 is ignored.
// Timing:
//   Keys pass through the queue and the back end's mask and output registers. The back end
//   loads a new mask only once the last is spent, emitting nothing then, and otherwise one
//   key per cycle while its output is free. Samples that fire nothing pass at one per cycle
//   while in_full is low. A four-entry queue absorbs bursts; in_full rises when it fills,
//   because samples bring keys faster than the back end drains them or out_pop stays low.
// Reset: synchronous, active low; restores the register defaults, clears the button
//   baseline, held direction and repeat time, and empties the queue and output.
module gamepad_nav_key_repeater_top
  import gnkr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  in_word_t   in_word,
  output logic       out_empty,
  input  logic       out_pop,
  output out_word_t  out_word,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  logic    accept, q_push, q_pop;
  q_word_t q_wdata, q_rdata;
  q_stat_t q_stat;

  assign cfg_ready = 1'b1;
  assign in_full   = q_stat.full;
  assign accept    = in_push && !q_stat.full;

  gnkr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_word   (in_word),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  gnkr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  gnkr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rdata   (q_rdata),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_word  (out_word)
  );

endmodule
